>>> rtl/implicit_list_heap_allocator_defines.svh
// Assertion macros shared by the allocator RTL.
// Each macro expects signals named clk and rst in the including scope.
`ifndef IMPLICIT_LIST_HEAP_ALLOCATOR_DEFINES_SVH
`define IMPLICIT_LIST_HEAP_ALLOCATOR_DEFINES_SVH

`ifndef SYNTHESIS

// Check a property on every clock edge outside reset.
`define ILHA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition in one cycle implies another in the next cycle.
`define ILHA_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`else

`define ILHA_ASSERT(lbl, prop, msg)
`define ILHA_ASSERT_NEXT(lbl, pre, post, msg)

`endif

`endif

>>> rtl/ilha_pkg.sv
`default_nettype none

package ilha_pkg;

  // Heap memory geometry.
  localparam int HEAP_WORDS = 1024;
  localparam int ADDR_W     = $clog2(HEAP_WORDS);
  localparam int WORD_W     = 16;

  // Widths of the byte-count fields and of the aligned sizes derived from them.
  localparam int BYTES_W = 12;
  localparam int NEED_W  = BYTES_W + 1;
  localparam int TOT_W   = BYTES_W + 2;

  // Width of pointer plus header-size-in-words.
  localparam int SUM_W = ((ADDR_W > WORD_W - 2) ? ADDR_W : WORD_W - 2) + 1;

  // Layout constants.
  localparam int HDR_BYTES = 4;
  localparam int ALIGN     = 8;
  localparam int INIT_PAD  = 12;

  localparam int HEAP_BYTES_RESET = 4084;
  localparam int CAP_BYTES   = ((HEAP_WORDS * HDR_BYTES) / ALIGN) * ALIGN;
  localparam int RESET_RAW   = ((HEAP_BYTES_RESET + INIT_PAD + ALIGN - 1) / ALIGN) * ALIGN;
  localparam int RESET_TOTAL = (RESET_RAW > CAP_BYTES) ? CAP_BYTES : RESET_RAW;
  localparam int END_RESET   = RESET_TOTAL / HDR_BYTES - 1;
  localparam int END_MIN     = ((INIT_PAD + ALIGN - 1) / ALIGN) * ALIGN / HDR_BYTES - 1;

  typedef enum logic [1:0] {
    MODE_ALLOC    = 2'd0,
    MODE_FREE     = 2'd1,
    MODE_COALESCE = 2'd2,
    MODE_INIT     = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOFIT   = 2'd1,
    ST_BADFREE = 2'd2
  } status_t;

  // Write port of the heap memory.
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [WORD_W-1:0] data;
  } ram_wr_t;

endpackage

`default_nettype wire

>>> rtl/ilha_if.sv
`default_nettype none

// Request channel: one heap operation.
interface ilha_req_if;
  logic                           valid;
  logic                           ready;
  ilha_pkg::mode_t                mode;
  logic [ilha_pkg::BYTES_W-1:0]   request_bytes;
  logic [ilha_pkg::ADDR_W-1:0]    block_word;

  modport source (output valid, output mode, output request_bytes, output block_word,
                  input ready);
  modport sink   (input valid, input mode, input request_bytes, input block_word,
                  output ready);
endinterface

// Response channel: one result per request.
interface ilha_rsp_if;
  logic                        valid;
  logic                        ready;
  ilha_pkg::status_t           status;
  logic [ilha_pkg::ADDR_W-1:0] alloc_word;

  modport source (output valid, output status, output alloc_word, input ready);
  modport sink   (input valid, input status, input alloc_word, output ready);
endinterface

`default_nettype wire

>>> rtl/ilha_heap_ram.sv
`default_nettype none

module ilha_heap_ram (
  input  wire logic                        clk,
  input  wire ilha_pkg::ram_wr_t           wr,
  input  wire logic [ilha_pkg::ADDR_W-1:0] raddr,
  output logic      [ilha_pkg::WORD_W-1:0] rdata
);
  import ilha_pkg::*;

  logic [WORD_W-1:0] mem [HEAP_WORDS];

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> rtl/implicit_list_heap_allocator.sv
// Init clears the heap one memory word per cycle and then lays it out again.
// Throughput: one request at a time; the header walk over the heap memory (separate read
//   and write ports) and the shared pointer adder set the rate (up to 511 headers for alloc or coalesce).
// Reset: synchronous; the block clears all 1024 heap words and lays out the heap from the
//   reset value of heap_bytes, with req.ready low and no response.
`default_nettype none
`include "implicit_list_heap_allocator_defines.svh"

module implicit_list_heap_allocator (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_we,
  input  wire logic [ilha_pkg::BYTES_W-1:0] cfg_wdata,
  ilha_req_if.sink                          req,
  ilha_rsp_if.source                        rsp
);
  import ilha_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_LAYOUT,
    S_IDLE,
    S_AWALK,
    S_ASPLIT,
    S_FCHK,
    S_CFIRST,
    S_CADV,
    S_CNEXT,
    S_DONE
  } state_t;

  state_t state;

  // Sequencer registers.
  logic [ADDR_W-1:0]  p;          // current header word
  logic [ADDR_W-1:0]  nx_r;       // next header word during coalesce
  logic [ADDR_W-1:0]  end_word;   // sentinel index
  logic [ADDR_W-1:0]  clr_cnt;    // clearing sweep address
  logic [BYTES_W-1:0] heap_bytes;
  logic [NEED_W-1:0]  need;       // aligned alloc block size
  logic [WORD_W-1:0]  cur_h;      // header at p during coalesce
  logic [WORD_W-1:0]  size_r;     // size of the block being split
  logic               init_reply;
  status_t            res_status;
  logic [ADDR_W-1:0]  res_word;

  // Response register.
  logic               out_valid;
  status_t            out_status;
  logic [ADDR_W-1:0]  out_word;

  // Memory ports.
  ram_wr_t            ram_wr;
  logic [ADDR_W-1:0]  raddr;
  logic [WORD_W-1:0]  rdata;

  // Datapath.
  logic [WORD_W-1:0]  rd_sz;
  logic [WORD_W-1:0]  cur_sz;
  logic [WORD_W-1:0]  size_cur;
  logic [WORD_W-3:0]  addend;
  logic [SUM_W-1:0]   step_sum;
  logic               past_end;
  logic               fit;
  logic [WORD_W-1:0]  merged;
  logic [NEED_W-1:0]  req_need;
  logic [TOT_W-1:0]   tot_raw;
  logic [TOT_W-1:0]   tot;
  logic [TOT_W-3:0]   tot_words;
  logic [ADDR_W-1:0]  end_calc;

  ilha_heap_ram u_ram (
    .clk   (clk),
    .wr    (ram_wr),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign req.ready      = (state == S_IDLE);
  assign rsp.valid      = out_valid;
  assign rsp.status     = out_status;
  assign rsp.alloc_word = out_word;

  // Drop the flag and spare bits to get the block size in bytes.
  assign rd_sz    = {rdata[WORD_W-1:3], 3'b000};
  assign cur_sz   = {cur_h[WORD_W-1:3], 3'b000};
  assign size_cur = (state == S_CADV) ? cur_sz : rd_sz;
  assign merged   = cur_sz + rd_sz;

  // Shared pointer adder: advance by a block size, or find the split point.
  assign addend   = (state == S_ASPLIT) ? (WORD_W - 2)'(need[NEED_W-1:2])
                                        : size_cur[WORD_W-1:2];
  assign step_sum = SUM_W'(p) + SUM_W'(addend);
  assign past_end = (step_sum >= SUM_W'(end_word));

  assign fit = !rdata[0] && (rd_sz >= WORD_W'(need));

  // Alloc size: payload plus header, rounded up to the alignment.
  assign req_need = (NEED_W'(req.request_bytes) + NEED_W'(HDR_BYTES + ALIGN - 1))
                  & ~NEED_W'(ALIGN - 1);

  // Heap span from the register: pad for header and sentinel, align, cap to the memory.
  assign tot_raw   = (TOT_W'(heap_bytes) + TOT_W'(INIT_PAD + ALIGN - 1))
                   & ~TOT_W'(ALIGN - 1);
  assign tot       = (32'(tot_raw) > CAP_BYTES) ? TOT_W'(CAP_BYTES) : tot_raw;
  assign tot_words = tot[TOT_W-1:2] - (TOT_W - 2)'(1);
  assign end_calc  = tot_words[ADDR_W-1:0];

  // Read address: the first header, the block to free, or the next header in the walk.
  always_comb begin
    case (state)
      S_IDLE:          raddr = (req.mode == MODE_FREE) ? req.block_word : ADDR_W'(1);
      S_AWALK, S_CADV: raddr = step_sum[ADDR_W-1:0];
      default:         raddr = p;
    endcase
  end

  // Write port: clear sweep, first free block, header updates.
  always_comb begin
    ram_wr.we   = 1'b0;
    ram_wr.addr = p;
    ram_wr.data = '0;
    case (state)
      S_CLEAR: begin
        ram_wr.we   = 1'b1;
        ram_wr.addr = clr_cnt;
      end
      S_LAYOUT: begin
        // The sentinel word is already zero after the sweep.
        ram_wr.we   = 1'b1;
        ram_wr.addr = ADDR_W'(1);
        ram_wr.data = WORD_W'(tot - TOT_W'(ALIGN));
      end
      S_AWALK: begin
        if (rd_sz != '0 && fit) begin
          ram_wr.we   = 1'b1;
          ram_wr.data = (rd_sz == WORD_W'(need)) ? (rd_sz | WORD_W'(1))
                                                 : (WORD_W'(need) | WORD_W'(1));
        end
      end
      S_ASPLIT: begin
        // Write the leftover free block only if it lands inside the memory.
        ram_wr.we   = (step_sum < SUM_W'(HEAP_WORDS));
        ram_wr.addr = step_sum[ADDR_W-1:0];
        ram_wr.data = size_r - WORD_W'(need);
      end
      S_FCHK: begin
        ram_wr.we   = rdata[0];
        ram_wr.data = {rdata[WORD_W-1:1], 1'b0};
      end
      S_CNEXT: begin
        if (rd_sz != '0 && !cur_h[0] && !rdata[0]) begin
          ram_wr.we   = 1'b1;
          ram_wr.data = merged;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_cnt    <= '0;
      heap_bytes <= BYTES_W'(HEAP_BYTES_RESET);
      end_word   <= ADDR_W'(END_RESET);
      init_reply <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        heap_bytes <= cfg_wdata;
      end
      // Drop the response once taken, unless a new one loads in the same cycle.
      if (out_valid && rsp.ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_CLEAR: begin
          // Sweep one word per cycle.
          clr_cnt <= clr_cnt + ADDR_W'(1);
          if (clr_cnt == '1) begin
            state <= S_LAYOUT;
          end
        end

        S_LAYOUT: begin
          end_word <= end_calc;
          if (init_reply) begin
            // Answer an init request; a reset layout gives no response.
            init_reply <= 1'b0;
            res_status <= ST_OK;
            res_word   <= '0;
            state      <= S_DONE;
          end else begin
            state <= S_IDLE;
          end
        end

        S_IDLE: begin
          if (req.valid) begin
            res_status <= (req.mode == MODE_ALLOC && end_word <= ADDR_W'(1)) ? ST_NOFIT
                                                                             : ST_OK;
            res_word   <= '0;
            p          <= (req.mode == MODE_FREE) ? req.block_word : ADDR_W'(1);
            need       <= req_need;
            case (req.mode)
              MODE_ALLOC: begin
                state <= (end_word > ADDR_W'(1)) ? S_AWALK : S_DONE;
              end
              MODE_FREE: begin
                state <= S_FCHK;
              end
              MODE_COALESCE: begin
                state <= (end_word > ADDR_W'(1)) ? S_CFIRST : S_DONE;
              end
              MODE_INIT: begin
                init_reply <= 1'b1;
                clr_cnt    <= '0;
                state      <= S_CLEAR;
              end
              default: state <= S_DONE;
            endcase
          end
        end

        S_AWALK: begin
          // One header per cycle: take it, advance and read the next one, or stop with no fit.
          if (rd_sz == '0) begin
            res_status <= ST_NOFIT;
            state      <= S_DONE;
          end else if (fit) begin
            res_word <= p;
            size_r   <= rd_sz;
            state    <= (rd_sz == WORD_W'(need)) ? S_DONE : S_ASPLIT;
          end else if (past_end) begin
            res_status <= ST_NOFIT;
            state      <= S_DONE;
          end else begin
            p <= step_sum[ADDR_W-1:0];
          end
        end

        S_ASPLIT: state <= S_DONE;

        S_FCHK: begin
          if (!rdata[0]) begin
            res_status <= ST_BADFREE;
          end
          state <= S_DONE;
        end

        S_CFIRST: begin
          cur_h <= rdata;
          state <= S_CADV;
        end

        S_CADV: begin
          // Stop at a zero size or once the neighbor reaches the sentinel.
          if (cur_sz == '0 || past_end) begin
            state <= S_DONE;
          end else begin
            nx_r  <= step_sum[ADDR_W-1:0];
            state <= S_CNEXT;
          end
        end

        S_CNEXT: begin
          if (rd_sz == '0) begin
            state <= S_DONE;
          end else begin
            if (!cur_h[0] && !rdata[0]) begin
              // Merge and hold p: the grown block may absorb its next neighbor too.
              cur_h <= merged;
            end else begin
              p     <= nx_r;
              cur_h <= rdata;
            end
            state <= S_CADV;
          end
        end

        S_DONE: begin
          // Hold the result until the response register is free.
          if (!out_valid || rsp.ready) begin
            out_valid  <= 1'b1;
            out_status <= res_status;
            out_word   <= res_word;
            state      <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  `ILHA_ASSERT(a_end_floor, end_word >= ADDR_W'(END_MIN), "sentinel below smallest layout")
  `ILHA_ASSERT(a_walk_bound, (state == S_AWALK || state == S_CADV || state == S_CNEXT) |-> (p < end_word), "walk pointer at or past sentinel")
  `ILHA_ASSERT(a_word_ok, (out_valid && out_word != '0) |-> (out_status == ST_OK), "granted word with error status")
  `ILHA_ASSERT_NEXT(a_busy, req.valid && req.ready, !req.ready, "request taken while busy")

endmodule

`default_nettype wire
